@@ hw/rtl/schedule_window_slot_finder_core_macros.svh @@
// Assertion macros used by the schedule window slot finder controller.
// Depends on nothing; the using module supplies clk and rst_n.
`ifndef SCHEDULE_WINDOW_SLOT_FINDER_CORE_MACROS_SVH
`define SCHEDULE_WINDOW_SLOT_FINDER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SWSF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SWSF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/swsf_pkg.sv @@
// Types, constants and helper functions of the schedule window slot finder.
// Used by the controller, the datapath and the top level; depends on nothing.
package swsf_pkg;

    localparam int KIND_W   = 2;
    localparam int BANK_W   = 1;
    localparam int ENTRY_W  = 5;
    localparam int TIME_W   = 64;
    localparam int DUR_W    = 32;
    localparam int PRIO_W   = 8;
    localparam int TARGET_W = 6;
    localparam int CODE_W   = 16;
    localparam int THR_W    = 6;
    localparam int LOW_W    = 32;

    // Timing codes that select a spacing threshold.
    localparam logic [CODE_W-1:0] CODE_FAST = 16'h0356;
    localparam logic [CODE_W-1:0] CODE_SLOW = 16'h05f5;
    localparam logic [CODE_W-1:0] CODE_MID  = 16'h018c;

    localparam logic [THR_W-1:0] THR_FAST    = 6'h1d;
    localparam logic [THR_W-1:0] THR_SLOW    = 6'h33;
    localparam logic [THR_W-1:0] THR_MID     = 6'h0e;
    localparam logic [THR_W-1:0] THR_DEFAULT = 6'h01;

    typedef enum logic [KIND_W-1:0] {
        KIND_QUERY = 2'd0,
        KIND_REC   = 2'd1,
        KIND_LINK  = 2'd2,
        KIND_HEAD  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_P1,
        ST_P2,
        ST_DONE
    } state_t;

    // One stored record: start time, precomputed end time, mark and rank.
    typedef struct packed {
        logic [TIME_W-1:0] start;
        logic [TIME_W-1:0] stop;
        logic              marked;
        logic [PRIO_W-1:0] rank;
    } rec_t;

    typedef struct packed {
        logic write_cfg;
        logic write_rec;
        logic write_link;
        logic write_head;
        logic load_query;
        logic pass_p1;
        logic enter_p2;
        logic take_p2;
        logic block;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic p1_stop;
        logic p2_clear;
        logic blocked;
        logic next_none;
        logic last_step;
    } stat_t;

    function automatic logic [THR_W-1:0] spacing_thr(input logic [CODE_W-1:0] code);
        logic [THR_W-1:0] thr;
        thr = THR_DEFAULT;
        if (code == CODE_FAST) thr = THR_FAST;
        else if (code == CODE_SLOW) thr = THR_SLOW;
        else if (code == CODE_MID) thr = THR_MID;
        return thr;
    endfunction

    // Signed 32-bit difference below a small positive threshold.
    function automatic logic below_thr(input logic [LOW_W-1:0] d,
                                       input logic [THR_W-1:0] thr);
        return d[LOW_W-1] || (d < LOW_W'(thr));
    endfunction

endpackage

@@ hw/rtl/swsf_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module swsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/swsf_datapath.sv @@
// Datapath of the slot finder: record and link memories, list heads, request
// and walk registers, result register. Depends on swsf_pkg and swsf_ram.
module swsf_datapath
    import swsf_pkg::*;
#(
    parameter int ENTRIES = 32,
    parameter int BANKS   = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [BANK_W-1:0]   bank,
    input  logic [ENTRY_W-1:0]  entry,
    input  logic [TIME_W-1:0]   time_start,
    input  logic [DUR_W-1:0]    duration,
    input  logic                spacing_flag,
    input  logic [PRIO_W-1:0]   priority_req,
    input  logic [TARGET_W-1:0] link_target,
    input  logic [CODE_W-1:0]   cfg_data,
    input  cmd_t                cmd,
    output stat_t               stat,
    output logic                fits,
    output logic [TARGET_W-1:0] previous_entry,
    output logic [TARGET_W-1:0] current_entry
);

    localparam int IDX_W      = $clog2(ENTRIES);
    localparam int PTR_W      = $clog2(ENTRIES + 1);
    localparam int LINK_DEPTH = BANKS * ENTRIES;
    localparam int LA_W       = $clog2(LINK_DEPTH);
    localparam int BSEL_W     = (BANKS > 1) ? $clog2(BANKS) : 1;
    localparam logic [PTR_W-1:0] NONE = PTR_W'(ENTRIES);

    logic [PTR_W-1:0]    heads_reg [BANKS];
    logic [CODE_W-1:0]   code_reg;
    logic [IDX_W-1:0]    steps_reg;

    logic [TIME_W-1:0]   req_start_reg;
    logic [TIME_W-1:0]   req_end_reg;
    logic                req_flag_reg;
    logic [PRIO_W-1:0]   req_prio_reg;
    logic [BSEL_W-1:0]   req_bank_reg;
    logic [PTR_W-1:0]    cur_reg;
    logic [PTR_W-1:0]    prev_reg;
    logic [PTR_W-1:0]    curout_reg;
    logic                fits_reg;
    logic                out_fits_reg;
    logic [PTR_W-1:0]    out_prev_reg;
    logic [PTR_W-1:0]    out_cur_reg;

    logic [BSEL_W-1:0]   bank_sel;
    logic                bank_ok;
    logic                entry_ok;
    logic [PTR_W-1:0]    tgt_clamped;
    logic [PTR_W-1:0]    head_in;
    logic [PTR_W-1:0]    cur_next;
    logic [BSEL_W-1:0]   rd_bank;
    logic [THR_W-1:0]    thr;
    logic [LOW_W-1:0]    start_lo;
    logic [LOW_W-1:0]    time_lo;

    rec_t                rec_wr;
    logic [$bits(rec_t)-1:0] rec_rd;
    rec_t                rec_q;
    logic [LA_W-1:0]     link_wr_addr;
    logic [LA_W-1:0]     link_rd_addr;
    logic [PTR_W-1:0]    link_q;

    assign bank_sel    = BSEL_W'(bank);
    assign bank_ok     = 32'(bank) < BANKS;
    assign entry_ok    = 32'(entry) < ENTRIES;
    assign tgt_clamped = (32'(link_target) >= ENTRIES) ? NONE : PTR_W'(link_target);
    assign head_in     = heads_reg[bank_sel];
    assign thr         = spacing_thr(code_reg);

    // Records keep their end time so that the walk needs only a compare.
    assign rec_wr.start  = time_start;
    assign rec_wr.stop   = time_start + TIME_W'(duration);
    assign rec_wr.marked = spacing_flag;
    assign rec_wr.rank   = priority_req;

    always_comb
    begin
        if (cmd.load_query)
        begin
            cur_next = head_in;
        end
        else if (cmd.pass_p1 || cmd.take_p2)
        begin
            cur_next = link_q;
        end
        else
        begin
            cur_next = cur_reg;
        end
    end

    assign rd_bank      = cmd.load_query ? bank_sel : req_bank_reg;
    assign link_wr_addr = LA_W'(bank_sel) * LA_W'(ENTRIES) + LA_W'(entry);
    assign link_rd_addr = LA_W'(rd_bank) * LA_W'(ENTRIES) + LA_W'(cur_next[IDX_W-1:0]);

    swsf_ram #(
        .WIDTH ($bits(rec_t)),
        .DEPTH (ENTRIES)
    ) u_rec_ram (
        .clk     (clk),
        .wr_en   (cmd.write_rec && entry_ok),
        .wr_addr (IDX_W'(entry)),
        .wr_data (rec_wr),
        .rd_addr (cur_next[IDX_W-1:0]),
        .rd_data (rec_rd)
    );

    swsf_ram #(
        .WIDTH (PTR_W),
        .DEPTH (LINK_DEPTH)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (cmd.write_link && bank_ok && entry_ok),
        .wr_addr (link_wr_addr),
        .wr_data (tgt_clamped),
        .rd_addr (link_rd_addr),
        .rd_data (link_q)
    );

    assign rec_q    = rec_t'(rec_rd);
    assign start_lo = req_start_reg[LOW_W-1:0];
    assign time_lo  = rec_q.start[LOW_W-1:0];

    assign stat.empty     = !bank_ok || (head_in >= NONE);
    assign stat.p1_stop   = (req_start_reg < rec_q.stop)
                          || (req_flag_reg && !rec_q.marked
                              && below_thr(start_lo - time_lo, thr));
    assign stat.p2_clear  = (rec_q.start >= req_end_reg)
                          && (!rec_q.marked || req_flag_reg
                              || !below_thr(time_lo - start_lo, thr));
    assign stat.blocked   = rec_q.rank <= req_prio_reg;
    assign stat.next_none = link_q >= NONE;
    assign stat.last_step = steps_reg == IDX_W'(ENTRIES - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < BANKS; b++)
            begin
                heads_reg[b] <= NONE;
            end
            code_reg  <= '0;
            steps_reg <= '0;
        end
        else
        begin
            if (cmd.write_cfg)
            begin
                code_reg <= cfg_data;
            end
            if (cmd.write_head && bank_ok)
            begin
                heads_reg[bank_sel] <= tgt_clamped;
            end
            if (cmd.load_query || cmd.enter_p2)
            begin
                steps_reg <= '0;
            end
            else if (cmd.pass_p1 || cmd.take_p2)
            begin
                steps_reg <= steps_reg + IDX_W'(1);
            end
        end
    end

    // In phase one the reported current entry always equals the previous one.
    always_ff @(posedge clk)
    begin
        if (cmd.load_query)
        begin
            req_start_reg <= time_start;
            req_end_reg   <= time_start + TIME_W'(duration);
            req_flag_reg  <= spacing_flag;
            req_prio_reg  <= priority_req;
            req_bank_reg  <= bank_sel;
            cur_reg       <= stat.empty ? NONE : head_in;
            prev_reg      <= NONE;
            curout_reg    <= NONE;
            fits_reg      <= 1'b1;
        end
        if (cmd.pass_p1)
        begin
            prev_reg   <= cur_reg;
            curout_reg <= cur_reg;
            cur_reg    <= link_q;
        end
        if (cmd.take_p2)
        begin
            curout_reg <= cur_reg;
            cur_reg    <= link_q;
        end
        if (cmd.block)
        begin
            fits_reg <= 1'b0;
        end
        if (cmd.load_out)
        begin
            out_fits_reg <= fits_reg;
            out_prev_reg <= prev_reg;
            out_cur_reg  <= curout_reg;
        end
    end

    assign fits           = out_fits_reg;
    assign previous_entry = TARGET_W'(out_prev_reg);
    assign current_entry  = TARGET_W'(out_cur_reg);

endmodule

@@ hw/rtl/swsf_ctrl.sv @@
// Controller of the slot finder: handshakes and the two-phase walk sequence.
// Depends on swsf_pkg and the assertion macro header.
`include "schedule_window_slot_finder_core_macros.svh"

module swsf_ctrl
    import swsf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  kind_t kind,
    output logic  out_valid,
    input  logic  out_ready,
    input  logic  cfg_valid,
    output logic  cfg_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic [3:0] step_cmds;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        in_ready       = 1'b0;
        cfg_ready      = 1'b1;
        cmd.write_cfg  = cfg_valid;
        out_valid_next = out_valid_reg && !out_ready;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (kind)
                        KIND_QUERY:
                        begin
                            cmd.load_query = 1'b1;
                            state_next     = stat.empty ? ST_DONE : ST_P1;
                        end
                        KIND_REC:  cmd.write_rec  = 1'b1;
                        KIND_LINK: cmd.write_link = 1'b1;
                        KIND_HEAD: cmd.write_head = 1'b1;
                        default:   ;
                    endcase
                end
            end
            ST_P1:
            begin
                if (stat.p1_stop)
                begin
                    cmd.enter_p2 = 1'b1;
                    state_next   = ST_P2;
                end
                else
                begin
                    cmd.pass_p1 = 1'b1;
                    if (stat.next_none || stat.last_step)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_P2:
            begin
                if (stat.p2_clear)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.take_p2 = 1'b1;
                    if (stat.blocked)
                    begin
                        cmd.block  = 1'b1;
                        state_next = ST_DONE;
                    end
                    else if (stat.next_none || stat.last_step)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign step_cmds = {cmd.load_query, cmd.pass_p1, cmd.enter_p2, cmd.take_p2};

    `SWSF_ASSERT_IMP(a_out_slot_free, cmd.load_out, !out_valid_reg || out_ready, "result overwritten")
    `SWSF_ASSERT_IMP(a_one_step_cmd, 1'b1, $onehot0(step_cmds), "conflicting walk commands")
    `SWSF_ASSERT_NXT(a_p1_limit, (state_reg == ST_P1) && !stat.p1_stop && stat.last_step, state_reg == ST_DONE, "phase one exceeded its step limit")
    `SWSF_ASSERT_NXT(a_p2_block, (state_reg == ST_P2) && !stat.p2_clear && stat.blocked, state_reg == ST_DONE, "blocked walk did not end")
    `SWSF_ASSERT_NXT(a_result_shown, cmd.load_out, out_valid_reg, "loaded result not shown")

endmodule

@@ hw/rtl/schedule_window_slot_finder_core.sv @@
// Top level of the schedule window slot finder.
// Depends on swsf_pkg, swsf_ctrl, swsf_datapath and swsf_ram.

// The block holds a table of ENTRIES scheduled records and, per bank, a linked
// order over them starting at a list head; the value ENTRIES in a link or head
// means "none". Input words of kind record, link or head update the tables and
// produce no result. A query word walks its bank's list and returns one result
// word (fits, previous_entry, current_entry). Phase one passes records that
// end at or before the request start unless the spacing rule stops it; phase
// two searches for a record clear of the request end, and ends with fits low
// at a record whose rank is at or below the request priority. Every walk step
// does one read of the record RAM and one of the link RAM; the record that
// stops phase one is read again by phase two, and a walk makes at most
// 2 * ENTRIES record reads. The next word is taken in the cycle after the
// result is loaded. New input words are taken only between queries, but a
// query may be accepted while the previous result still waits in the output
// register. Records and links hold garbage until written, so lists must only
// point at written entries. The configuration word on cfg_data sets the PHY
// timing code that selects the spacing threshold; it may be written only while
// no query is in flight.
module schedule_window_slot_finder_core
    import swsf_pkg::*;
#(
    parameter int ENTRIES = 32,
    parameter int BANKS   = 2
) (
    input  logic                clk,
    input  logic                rst_n,

    input  logic                in_valid,
    output logic                in_ready,
    input  logic [KIND_W-1:0]   kind,
    input  logic [BANK_W-1:0]   bank,
    input  logic [ENTRY_W-1:0]  entry,
    input  logic [TIME_W-1:0]   time_start,
    input  logic [DUR_W-1:0]    duration,
    input  logic                spacing_flag,
    input  logic [PRIO_W-1:0]   priority_req,
    input  logic [TARGET_W-1:0] link_target,

    output logic                out_valid,
    input  logic                out_ready,
    output logic                fits,
    output logic [TARGET_W-1:0] previous_entry,
    output logic [TARGET_W-1:0] current_entry,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CODE_W-1:0]   cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    // The controller sequences the walk; the datapath owns all storage.
    swsf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind_t'(kind)),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    swsf_datapath #(
        .ENTRIES (ENTRIES),
        .BANKS   (BANKS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .bank           (bank),
        .entry          (entry),
        .time_start     (time_start),
        .duration       (duration),
        .spacing_flag   (spacing_flag),
        .priority_req   (priority_req),
        .link_target    (link_target),
        .cfg_data       (cfg_data),
        .cmd            (cmd),
        .stat           (stat),
        .fits           (fits),
        .previous_entry (previous_entry),
        .current_entry  (current_entry)
    );

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for schedule_window_slot_finder_core.
// Depends on swsf_pkg and the core RTL; holds its own slot predictor and
// drives the input and result channels with random idle gaps and writes timing codes.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import swsf_pkg::*;

    localparam int ENTRIES      = 32;
    localparam int BANKS        = 2;
    localparam int NONE         = 32;
    // A query walks at most 2 * ENTRIES records.
    localparam int WALK_LATENCY = 80;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_WORDS  = 170;
    localparam int MAX_REPORTS  = 10;
    localparam int CYCLE_LIMIT  = 1000000;

    // One result word as the core reports it.
    typedef struct packed {
        logic                fits;
        logic [TARGET_W-1:0] prev;
        logic [TARGET_W-1:0] cur;
    } slot_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    kind_t               kind_d = KIND_QUERY;
    logic [BANK_W-1:0]   bank_d = '0;
    logic [ENTRY_W-1:0]  entry_d = '0;
    logic [TIME_W-1:0]   time_d = '0;
    logic [DUR_W-1:0]    duration_d = '0;
    logic                flag_d = 1'b0;
    logic [PRIO_W-1:0]   prio_d = '0;
    logic [TARGET_W-1:0] target_d = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic                fits;
    logic [TARGET_W-1:0] previous_entry;
    logic [TARGET_W-1:0] current_entry;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CODE_W-1:0]   cfg_data = '0;

    // Shadow copy of the core's tables and timing code.
    logic [TIME_W-1:0]   rec_start [ENTRIES];
    logic [DUR_W-1:0]    rec_span  [ENTRIES];
    logic                rec_mark  [ENTRIES];
    logic [PRIO_W-1:0]   rec_rank  [ENTRIES];
    logic [TARGET_W-1:0] succ      [BANKS][ENTRIES];
    logic [TARGET_W-1:0] head_of   [BANKS] = '{6'd32, 6'd32};
    logic [CODE_W-1:0]   timing_code = '0;

    // Results predicted for accepted queries, oldest first.
    slot_t pending_slots [$];

    int  fail_count = 0;
    int  words_sent = 0;
    int  cycle_count = 0;
    int  long_hold_cycles = 0;
    // While set, neither side inserts random idle cycles.
    bit  steady = 1'b0;

    schedule_window_slot_finder_core #(
        .ENTRIES (ENTRIES),
        .BANKS   (BANKS)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind_d),
        .bank           (bank_d),
        .entry          (entry_d),
        .time_start     (time_d),
        .duration       (duration_d),
        .spacing_flag   (flag_d),
        .priority_req   (prio_d),
        .link_target    (target_d),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .fits           (fits),
        .previous_entry (previous_entry),
        .current_entry  (current_entry),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Spacing threshold selected by the PHY timing code.
    function automatic int spacing_limit(input logic [CODE_W-1:0] code);
        case (code)
            CODE_FAST: return 29;
            CODE_SLOW: return 51;
            CODE_MID:  return 14;
            default:   return 1;
        endcase
    endfunction

    // A low-word difference read as signed 32 bits, compared with the threshold.
    function automatic logic too_close(input logic [31:0] d, input int limit);
        return d[31] || (d < 32'(limit));
    endfunction

    function automatic slot_t slot_of(input logic f, input int p, input int c);
        slot_t s;
        s.fits = f;
        s.prev = TARGET_W'(p);
        s.cur  = TARGET_W'(c);
        return s;
    endfunction

    // Walks the shadow list of one bank the way the core does and returns
    // the bracketing entries for the requested window.
    function automatic slot_t predict_slot(input logic b, input logic [TIME_W-1:0] st,
                                           input logic [DUR_W-1:0] span, input logic flg,
                                           input logic [PRIO_W-1:0] pr);
        int limit;
        int prev;
        int cur;
        int cur_out;
        logic [TIME_W-1:0] rec_end;
        logic [TIME_W-1:0] req_end;
        limit = spacing_limit(timing_code);
        prev = NONE;
        cur = head_of[b];
        if (cur >= ENTRIES)
            return slot_of(1'b1, NONE, NONE);

        // Phase one: pass records that end at or before the request start.
        for (int step = 0; step <= ENTRIES; step++)
        begin
            if (step == ENTRIES)
                return slot_of(1'b1, prev, prev);
            rec_end = rec_start[cur] + TIME_W'(rec_span[cur]);
            if (st < rec_end)
                break;
            if (flg && !rec_mark[cur] &&
                too_close(st[31:0] - rec_start[cur][31:0], limit))
                break;
            prev = cur;
            cur = succ[b][cur];
            if (cur >= ENTRIES)
                return slot_of(1'b1, prev, prev);
        end

        // Phase two: look for a record clear of the request end.
        req_end = st + TIME_W'(span);
        cur_out = prev;
        for (int step = 0; step < ENTRIES; step++)
        begin
            if (rec_start[cur] >= req_end)
            begin
                if (!rec_mark[cur] || flg ||
                    !too_close(rec_start[cur][31:0] - st[31:0], limit))
                    return slot_of(1'b1, prev, cur_out);
            end
            cur_out = cur;
            if (rec_rank[cur] <= pr)
                return slot_of(1'b0, prev, cur_out);
            cur = succ[b][cur];
            if (cur >= ENTRIES)
                return slot_of(1'b1, prev, cur_out);
        end
        return slot_of(1'b1, prev, cur_out);
    endfunction

    function automatic logic [TARGET_W-1:0] clamp_target(input logic [TARGET_W-1:0] t);
        return (t >= NONE) ? TARGET_W'(NONE) : t;
    endfunction

    // Applies one accepted word to the shadow state, or predicts its result.
    function automatic void apply_word(input kind_t k, input logic b,
                                       input logic [ENTRY_W-1:0] e,
                                       input logic [TIME_W-1:0] t,
                                       input logic [DUR_W-1:0] d, input logic f,
                                       input logic [PRIO_W-1:0] p,
                                       input logic [TARGET_W-1:0] lt);
        case (k)
            KIND_REC:
            begin
                rec_start[e] = t;
                rec_span[e]  = d;
                rec_mark[e]  = f;
                rec_rank[e]  = p;
            end
            KIND_LINK: succ[b][e] = clamp_target(lt);
            KIND_HEAD: head_of[b] = clamp_target(lt);
            default:   pending_slots.push_back(predict_slot(b, t, d, f, p));
        endcase
    endfunction

    function automatic void report_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("mismatch %0d at %0t: %s", fail_count, $realtime, msg);
    endfunction

    // Idle lengths: mostly short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    // Offers one input word and holds it until the core takes it. Must be
    // called at a rising edge; returns at the edge where the word was taken.
    task automatic send_word(input kind_t k, input logic b, input logic [ENTRY_W-1:0] e,
                             input logic [TIME_W-1:0] t, input logic [DUR_W-1:0] d,
                             input logic f, input logic [PRIO_W-1:0] p,
                             input logic [TARGET_W-1:0] lt);
        in_valid   <= 1'b1;
        kind_d     <= k;
        bank_d     <= b;
        entry_d    <= e;
        time_d     <= t;
        duration_d <= d;
        flag_d     <= f;
        prio_d     <= p;
        target_d   <= lt;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        apply_word(k, b, e, t, d, f, p, lt);
        words_sent++;
    endtask

    // Fields a word does not use are randomized so that every bit toggles.
    task automatic set_record(input int e, input logic [TIME_W-1:0] t,
                              input logic [DUR_W-1:0] len, input logic mark,
                              input logic [PRIO_W-1:0] rank);
        send_word(KIND_REC, 1'($urandom), ENTRY_W'(e), t, len, mark, rank,
                  TARGET_W'($urandom));
    endtask

    task automatic set_link(input logic b, input int e, input logic [TARGET_W-1:0] tgt);
        send_word(KIND_LINK, b, ENTRY_W'(e), {$urandom, $urandom}, $urandom,
                  1'($urandom), PRIO_W'($urandom), tgt);
    endtask

    task automatic set_head(input logic b, input logic [TARGET_W-1:0] tgt);
        send_word(KIND_HEAD, b, ENTRY_W'($urandom), {$urandom, $urandom}, $urandom,
                  1'($urandom), PRIO_W'($urandom), tgt);
    endtask

    task automatic ask_slot(input logic b, input logic [TIME_W-1:0] t,
                            input logic [DUR_W-1:0] d, input logic f,
                            input logic [PRIO_W-1:0] p);
        send_word(KIND_QUERY, b, ENTRY_W'($urandom), t, d, f, p, TARGET_W'($urandom));
    endtask

    // Random idle time on the input side between words.
    task automatic sender_pause();
        int gap;
        if (steady || $urandom_range(0, 99) < 55)
            gap = 0;
        else
            gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stops offering words until every predicted result has come back, then
    // lets a full walk time pass so that the core is surely idle.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_slots.size() != 0)
            @(posedge clk);
        repeat (WALK_LATENCY) @(posedge clk);
    endtask

    task automatic write_timing_code(input logic [CODE_W-1:0] code);
        cfg_valid <= 1'b1;
        cfg_data  <= code;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        timing_code = code;
    endtask

    // Right after reset both lists are empty; no record is read yet.
    task automatic test_empty_lists();
        ask_slot(1'b0, '0, '0, 1'b0, '0);
        ask_slot(1'b1, '1, '1, 1'b1, '1);
    endtask

    // Writes every record and every link once, so that no walk can ever read
    // an entry that holds garbage. Bank 0 is a sorted chain over all entries,
    // bank 1 pairs entries into two-element cycles.
    task automatic load_tables();
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (i == ENTRIES - 1)
                set_record(i, 64'hFFFF_FFFF_FFFF_FF00, '1, 1'b1, 8'd252);
            else
                set_record(i, TIME_W'(i * 100), (i == 0) ? 32'd0 : 32'd50, i[0],
                           PRIO_W'(8 * i + 4));
            sender_pause();
        end
        for (int i = 0; i < ENTRIES; i++)
        begin
            set_link(1'b0, i, (i == ENTRIES - 1) ? 6'd63 : TARGET_W'(i + 1));
            set_link(1'b1, i, TARGET_W'(i ^ 1));
            sender_pause();
        end
    endtask

    // Hand-picked queries over the loaded tables, one per corner of the walk.
    task automatic test_walk_cases();
        set_head(1'b0, 6'd0);
        // Zero-length first record, then a clear second record.
        ask_slot(1'b0, '0, '0, 1'b0, '0);
        // Spacing rule stops phase one on the unmarked zero-length record.
        ask_slot(1'b0, '0, 32'd10, 1'b1, '0);
        // Window overlapping later records, low and high request priority.
        ask_slot(1'b0, 64'd250, 32'd1000, 1'b0, 8'd0);
        ask_slot(1'b0, 64'd250, 32'd1000, 1'b1, 8'd255);
        // Start past every record: the list runs out in phase one.
        ask_slot(1'b0, '1, '0, 1'b0, 8'd0);
        // Bank 1 cycles 0 <-> 1: phase one then phase two hit the step limit.
        set_head(1'b1, 6'd0);
        ask_slot(1'b1, 64'h0000_0001_0000_0000, 32'd5, 1'b0, 8'd0);
        ask_slot(1'b1, '0, '1, 1'b0, 8'd0);
        // Head targets of 32 and above both mean an empty list.
        set_head(1'b1, 6'd40);
        ask_slot(1'b1, 64'd120, 32'd7, 1'b1, 8'd3);
        set_head(1'b1, 6'd32);
        ask_slot(1'b1, 64'd120, 32'd7, 1'b0, 8'd3);
        // Extreme record whose end time wraps, and an explicit end of chain.
        set_record(5, '1, '1, 1'b1, 8'd255);
        set_link(1'b0, 4, 6'd32);
        set_link(1'b0, 5, 6'd63);
        ask_slot(1'b0, 64'd460, 32'd20, 1'b0, 8'd100);
        set_link(1'b0, 4, 6'd5);
        ask_slot(1'b0, 64'd460, 32'd20, 1'b1, 8'd254);
        ask_slot(1'b0, 64'd460, 32'd0, 1'b0, 8'd255);
        set_head(1'b1, 6'd2);
    endtask

    // The receiver stops taking results for a long stretch while queries keep
    // coming, so the output register fills and the core holds off its input.
    task automatic test_output_backpressure();
        steady = 1'b1;
        long_hold_cycles = HOLD_CYCLES;
        repeat (14)
            ask_slot(1'($urandom), TIME_W'($urandom_range(0, 3300)),
                     DUR_W'($urandom_range(0, 400)), 1'($urandom), PRIO_W'($urandom));
        steady = 1'b0;
        drain();
    endtask

    // A word with every field random, of any kind.
    task automatic noise_word();
        send_word(kind_t'($urandom_range(0, 3)), 1'($urandom), ENTRY_W'($urandom),
                  {$urandom, $urandom}, $urandom, 1'($urandom), PRIO_W'($urandom),
                  TARGET_W'($urandom_range(0, 63)));
        sender_pause();
    endtask

    // Builds a list of 1 to ENTRIES records on one bank, spaced by step with a
    // jitter of up to 5, and queries it with windows placed around those records.
    task automatic build_and_query();
        int order [ENTRIES];
        int k;
        int step;
        int n;
        int j;
        int tmp;
        logic b;
        logic [TIME_W-1:0] base;
        logic [DUR_W-1:0] len;
        logic [DUR_W-1:0] dur;
        logic [TARGET_W-1:0] tail;
        longint off;
        b = 1'($urandom);
        for (int i = 0; i < ENTRIES; i++)
            order[i] = i;
        for (int i = ENTRIES - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        k = ($urandom_range(0, 9) == 0) ? $urandom_range(9, ENTRIES) : $urandom_range(1, 8);
        step = $urandom_range(0, 60);
        case ($urandom_range(0, 3))
            0: base = {$urandom, $urandom};
            1: base = TIME_W'($urandom_range(0, 100));
            // Near the top of the time range, so that ends and windows wrap.
            2: base = '1 - TIME_W'(k * step) - TIME_W'($urandom_range(0, 100));
            // Low word about to wrap, to exercise the signed spacing difference.
            default: base = {$urandom, 32'hFFFF_FF00 + 32'($urandom_range(0, 200))};
        endcase

        for (int i = 0; i < k; i++)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom : DUR_W'($urandom_range(0, step + 8));
            set_record(order[i], base + TIME_W'(i * step) + TIME_W'($urandom_range(0, 5)),
                       len, 1'($urandom), PRIO_W'($urandom));
            sender_pause();
        end
        for (int i = 0; i < k - 1; i++)
        begin
            set_link(b, order[i], TARGET_W'(order[i + 1]));
            sender_pause();
        end
        // The chain ends, loops back into itself, or jumps to another entry.
        case ($urandom_range(0, 4))
            0, 1: tail = TARGET_W'($urandom_range(32, 63));
            2:    tail = TARGET_W'(NONE);
            3:    tail = TARGET_W'(order[$urandom_range(0, k - 1)]);
            default: tail = TARGET_W'($urandom_range(0, 31));
        endcase
        set_link(b, order[k - 1], tail);
        sender_pause();
        if ($urandom_range(0, 19) == 0)
            set_head(b, TARGET_W'($urandom_range(32, 63)));
        else
            set_head(b, TARGET_W'(order[0]));
        sender_pause();

        n = $urandom_range(3, 8);
        for (int i = 0; i < n; i++)
        begin
            off = longint'($urandom_range(0, k * step + 80)) - 40;
            case ($urandom_range(0, 9))
                0, 1:    dur = $urandom;
                2, 3, 4: dur = DUR_W'($urandom_range(0, k * step + 10));
                default: dur = DUR_W'($urandom_range(0, 2 * step + 10));
            endcase
            ask_slot(b, base + TIME_W'(off), dur, 1'($urandom), PRIO_W'($urandom));
            sender_pause();
        end
    endtask

    task automatic run_random_phase(input int words);
        int stop_at;
        stop_at = words_sent + words;
        while (words_sent < stop_at)
        begin
            if ($urandom_range(0, 99) < 15)
                noise_word();
            else
                build_and_query();
        end
    endtask

    // Each timing code gets its own phase; the register is only written once
    // the core has gone idle. The first half of one phase runs without gaps.
    task automatic test_timing_codes();
        logic [CODE_W-1:0] codes [6];
        codes = '{CODE_FAST, CODE_SLOW, CODE_MID, 16'h0000, 16'hFFFF, CODE_W'($urandom)};
        foreach (codes[i])
        begin
            drain();
            write_timing_code(codes[i]);
            if (i == 2)
            begin
                steady = 1'b1;
                run_random_phase(PHASE_WORDS / 2);
                steady = 1'b0;
                run_random_phase(PHASE_WORDS / 2);
            end
            else
                run_random_phase(PHASE_WORDS);
        end
    endtask

    // Result side: stalls of random length, plus the long hold when asked.
    initial
    begin : result_sink
        int gap;
        @(posedge clk);
        forever
        begin
            if (long_hold_cycles > 0)
            begin
                gap = long_hold_cycles;
                long_hold_cycles = 0;
                out_ready <= 1'b0;
            end
            else if (!steady && $urandom_range(0, 99) < 25)
            begin
                gap = pick_gap();
                out_ready <= 1'b0;
            end
            else
            begin
                gap = 1;
                out_ready <= 1'b1;
            end
            repeat (gap) @(posedge clk);
        end
    end

    // Every taken result word is matched against the oldest prediction.
    always @(posedge clk)
    begin : result_check
        slot_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_slots.size() == 0)
                report_failure($sformatf("unexpected result fits=%0d prev=%0d cur=%0d",
                                         fits, previous_entry, current_entry));
            else
            begin
                want = pending_slots.pop_front();
                if (want.fits !== fits || want.prev !== previous_entry ||
                    want.cur !== current_entry)
                    report_failure($sformatf(
                        "expected fits=%0d prev=%0d cur=%0d, got fits=%0d prev=%0d cur=%0d",
                        want.fits, want.prev, want.cur, fits, previous_entry,
                        current_entry));
            end
        end
    end

    // Guards against a hung core or a lost result.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[schedule_window_slot_finder_core] ERROR");
            $finish;
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_lists();
        load_tables();
        test_walk_cases();
        test_output_backpressure();
        test_timing_codes();
        drain();
        if (fail_count == 0 && pending_slots.size() == 0)
            $display("[schedule_window_slot_finder_core] OK");
        else
            $display("[schedule_window_slot_finder_core] ERROR");
        $finish;
    end

endmodule
